// File: rtl/core/crcg_pkg.sv
// Shared types and constants for the cable/rod contact generator.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps
package crcg_pkg;

  localparam int NumAxes   = 3;
  localparam int RootBits  = 26;           // floor sqrt of a 52-bit sum
  localparam int QuotBits  = 15;           // normal magnitude, at most 16384
  localparam int SumBits   = 2 * RootBits;
  localparam int SqBits    = 50;
  localparam int DiffBits  = 25;
  localparam int NumBits   = 42;           // normal numerator and remainder
  localparam int DivBits   = RootBits + 1; // twice the length

  localparam logic [16:0] BounceMax = 17'd65536;

  // Pipeline stage map
  localparam int StDiff = 0;
  localparam int StSq   = 1;
  localparam int StSum  = 2;
  localparam int StRt0  = 3;
  localparam int StSet  = StRt0 + RootBits;
  localparam int StDv0  = StSet + 1;
  localparam int NumStages = StDv0 + QuotBits;

  typedef enum logic {
    LINK_CABLE = 1'b0,
    LINK_ROD   = 1'b1
  } link_kind_t;

  typedef struct packed {
    logic               req_type;
    logic signed [23:0] pos_a_x;
    logic signed [23:0] pos_a_y;
    logic signed [23:0] pos_a_z;
    logic signed [23:0] pos_b_x;
    logic signed [23:0] pos_b_y;
    logic signed [23:0] pos_b_z;
    logic [23:0]        rest_length;
    logic [16:0]        bounce;
    logic [15:0]        link_tag;
  } link_t;

  typedef struct packed {
    logic               contact_valid;
    logic [24:0]        penetration;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [16:0]        contact_bounce;
    logic               degenerate;
    logic [15:0]        result_tag;
  } contact_t;

  // Everything one item carries down the pipeline
  typedef struct packed {
    logic                                  rod;
    logic [NumAxes-1:0][DiffBits-1:0]      d;
    logic [NumAxes-1:0][SqBits-1:0]        sq;
    logic [SumBits-1:0]                    rem;
    logic [RootBits-1:0]                   root;
    logic [23:0]                           rest;
    logic [16:0]                           bounce;
    logic [15:0]                           tag;
    logic                                  contact;
    logic                                  flip;
    logic [24:0]                           pen;
    logic [DivBits-1:0]                    dvs;
    logic [NumAxes-1:0][NumBits-1:0]       nrem;
    logic [NumAxes-1:0][QuotBits-1:0]      q;
  } pipe_t;

endpackage

// File: rtl/core/crcg_stream_if.sv
// Valid/ready stream channel carrying one word of type T.
// Depends on nothing; payload types come from crcg_pkg at the instance.
`timescale 1ns / 1ps
interface crcg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/cable_rod_contact_generator_unit.sv
// Cable/rod contact generator: a fully pipelined unit, one link word in and
// one contact word out per cycle while the output is not stalled. An item
// passes through difference, square and sum stages, 26 square-root stages
// (one root bit each), a setup stage and 15 divider stages (one quotient bit
// per axis each) into the output register. Every stage holds its word until
// the next frees up, so bubbles collapse and a stall at the output backs up
// without loss. Depends on crcg_pkg and crcg_stream_if.
`timescale 1ns / 1ps
module cable_rod_contact_generator_unit (
  input  logic clk,
  input  logic rst,
  crcg_stream_if.sink   req,
  crcg_stream_if.source rsp
);

  localparam int NS = crcg_pkg::NumStages;

  crcg_pkg::pipe_t st [NS];
  crcg_pkg::pipe_t st_next [NS];
  logic [NS-1:0]   vld;
  logic [NS:0]     load;
  crcg_pkg::contact_t rsp_word;
  crcg_pkg::contact_t rsp_word_next;
  logic            rsp_vld;

  crcg_pkg::pipe_t         src;
  logic [crcg_pkg::SumBits-1:0] rt_trial;
  logic [crcg_pkg::NumBits-1:0] dv_trial;
  logic signed [49:0]      prod;
  logic [24:0]             mag;
  logic [25:0]             len_x;
  logic [25:0]             rest_x;
  logic                    compressed;
  int                      rb;
  int                      db;

  // Ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    load[NS] = !rsp_vld || rsp.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign req.ready = load[0];

  // Per-stage work
  always_comb begin
    src = '0; rt_trial = '0; dv_trial = '0; prod = '0; mag = '0;
    len_x = '0; rest_x = '0; compressed = 1'b0; rb = 0; db = 0;
    for (int k = 0; k < NS; k++) begin
      src = (k == 0) ? '0 : st[(k == 0) ? 0 : k - 1];
      st_next[k] = src;
      if (k == crcg_pkg::StDiff) begin
        st_next[k].rod    = req.data.req_type;
        st_next[k].d[0]   = 25'($signed({req.data.pos_b_x[23], req.data.pos_b_x})
                              - $signed({req.data.pos_a_x[23], req.data.pos_a_x}));
        st_next[k].d[1]   = 25'($signed({req.data.pos_b_y[23], req.data.pos_b_y})
                              - $signed({req.data.pos_a_y[23], req.data.pos_a_y}));
        st_next[k].d[2]   = 25'($signed({req.data.pos_b_z[23], req.data.pos_b_z})
                              - $signed({req.data.pos_a_z[23], req.data.pos_a_z}));
        st_next[k].rest   = req.data.rest_length;
        st_next[k].bounce = req.data.bounce;
        st_next[k].tag    = req.data.link_tag;
      end else if (k == crcg_pkg::StSq) begin
        // square each difference
        for (int c = 0; c < crcg_pkg::NumAxes; c++) begin
          prod = $signed(src.d[c]) * $signed(src.d[c]);
          st_next[k].sq[c] = prod[49:0];
        end
      end else if (k == crcg_pkg::StSum) begin
        st_next[k].rem  = crcg_pkg::SumBits'(src.sq[0]) + crcg_pkg::SumBits'(src.sq[1])
                        + crcg_pkg::SumBits'(src.sq[2]);
        st_next[k].root = '0;
      end else if (k < crcg_pkg::StSet) begin
        // settle one root bit: try (root + b)^2 against the remainder
        rb = crcg_pkg::RootBits - 1 - (k - crcg_pkg::StRt0);
        rt_trial = (crcg_pkg::SumBits'(src.root) << (rb + 1))
                 + (crcg_pkg::SumBits'(1) << (2 * rb));
        if (src.rem >= rt_trial) begin
          st_next[k].rem  = src.rem - rt_trial;
          st_next[k].root = src.root | (crcg_pkg::RootBits'(1) << rb);
        end
      end else if (k == crcg_pkg::StSet) begin
        // contact decision, penetration and rounded-division setup
        len_x      = src.root;
        rest_x     = {2'b00, src.rest};
        compressed = len_x < rest_x;
        st_next[k].contact = (src.rod == crcg_pkg::LINK_ROD) ? (len_x != rest_x)
                                                             : !compressed;
        st_next[k].flip    = (src.rod == crcg_pkg::LINK_ROD) && compressed;
        st_next[k].pen     = compressed ? 25'(rest_x - len_x) : 25'(len_x - rest_x);
        st_next[k].dvs     = {len_x, 1'b0};
        for (int c = 0; c < crcg_pkg::NumAxes; c++) begin
          mag = src.d[c][24] ? 25'(-src.d[c]) : src.d[c];
          st_next[k].nrem[c] = {2'b00, mag, 15'd0} + crcg_pkg::NumBits'(len_x);
          st_next[k].q[c]    = '0;
        end
      end else begin
        // settle one quotient bit per axis
        db = crcg_pkg::QuotBits - 1 - (k - crcg_pkg::StDv0);
        dv_trial = crcg_pkg::NumBits'(src.dvs) << db;
        for (int c = 0; c < crcg_pkg::NumAxes; c++) begin
          if (src.nrem[c] >= dv_trial) begin
            st_next[k].nrem[c] = src.nrem[c] - dv_trial;
            st_next[k].q[c]    = src.q[c] | (crcg_pkg::QuotBits'(1) << db);
          end
        end
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (load[k]) begin
        st[k] <= st_next[k];
      end
    end
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (load[k]) begin
          vld[k] <= (k == 0) ? req.valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Format the result word
  always_comb begin
    crcg_pkg::pipe_t  last;
    logic             deg;
    logic [15:0]      nq [crcg_pkg::NumAxes];
    last = st[NS-1];
    deg  = (last.root == '0);
    for (int c = 0; c < crcg_pkg::NumAxes; c++) begin
      if (deg) begin
        nq[c] = '0;
      end else if (last.d[c][24] != last.flip) begin
        nq[c] = 16'(-{1'b0, last.q[c]});
      end else begin
        nq[c] = {1'b0, last.q[c]};
      end
    end
    rsp_word_next = '0;
    rsp_word_next.result_tag = last.tag;
    if (last.contact) begin
      rsp_word_next.contact_valid = 1'b1;
      rsp_word_next.penetration   = last.pen;
      rsp_word_next.normal_x      = nq[0];
      rsp_word_next.normal_y      = nq[1];
      rsp_word_next.normal_z      = nq[2];
      rsp_word_next.degenerate    = deg;
      if (last.rod == crcg_pkg::LINK_CABLE) begin
        rsp_word_next.contact_bounce = (last.bounce > crcg_pkg::BounceMax)
                                     ? crcg_pkg::BounceMax : last.bounce;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load[NS]) begin
      rsp_word <= rsp_word_next;
    end
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (load[NS]) begin
      rsp_vld <= vld[NS-1];
    end
  end

  assign rsp.valid = rsp_vld;
  assign rsp.data  = rsp_word;

  // A word without a contact carries nothing but its tag
  a_no_contact_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_vld && !rsp_word.contact_valid |->
      rsp_word.penetration == '0 && !rsp_word.degenerate && rsp_word.contact_bounce == '0)
    else $error("non-contact word carries payload");

  // Coinciding particles give a zero normal
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_vld && rsp_word.degenerate |->
      rsp_word.normal_x == '0 && rsp_word.normal_y == '0 && rsp_word.normal_z == '0)
    else $error("degenerate contact with nonzero normal");

  // Restitution never exceeds one
  a_bounce_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_vld |-> rsp_word.contact_bounce <= crcg_pkg::BounceMax)
    else $error("contact bounce above one");

  // A stalled output register keeps the stage behind it from draining
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_vld && !rsp.ready && vld[NS-1] |=> vld[NS-1])
    else $error("last stage drained during output stall");

endmodule
